[hdl/odf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odf_pkg: shared types and constants for the occupancy drop FIFO
// Register indexes, reset values, drop level constants, result codes and
// the control word that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package odf_pkg;

    localparam int ODF_QUEUE_DEPTH = 32;
    localparam int ODF_LENGTH_BITS = 11;

    localparam int REG_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int SEQ_W     = 16;
    localparam int SRC_W     = 8;
    localparam int DRAW_W    = 4;
    localparam int OUTCOME_W = 3;
    localparam int LEVEL_W   = 4;
    localparam int OCC_W     = 6;

    // front end command queue
    localparam int FQ_DEPTH = 2;
    localparam int FQ_PTR_W = 1;
    localparam int FQ_CNT_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT    = 2'd2;

    localparam logic [REG_W-1:0] LOW_THRESHOLD_RESET  = 6'd11;
    localparam logic [REG_W-1:0] HIGH_THRESHOLD_RESET = 6'd20;
    localparam logic [REG_W-1:0] QUEUE_LIMIT_RESET    = 6'd20;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 4'd10;
    localparam logic [LEVEL_W-1:0] LEVEL_NONE = 4'd0;
    localparam int LEVEL_KNEE  = 5;
    localparam int LEVEL_BOOST = 5;

    typedef logic [OUTCOME_W-1:0] outcome_t;

    localparam outcome_t OUT_QUEUED  = 3'd0;
    localparam outcome_t OUT_RANDOM  = 3'd1;
    localparam outcome_t OUT_FULL    = 3'd2;
    localparam outcome_t OUT_FORWARD = 3'd3;
    localparam outcome_t OUT_EMPTY   = 3'd4;

    typedef struct packed {
        logic              is_fwd;
        logic [DRAW_W-1:0] draw;
    } odf_cmd_t;

endpackage

[hdl/odf_intf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odf_intf: request and response channels of the occupancy drop FIFO
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface odf_req_if import odf_pkg::*; #(
    parameter int LENGTH_BITS = ODF_LENGTH_BITS
);
    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [SEQ_W-1:0]       seq_number;
    logic [SRC_W-1:0]       source_number;
    logic                   toward_b;
    logic [LENGTH_BITS-1:0] body_length;
    logic [DRAW_W-1:0]      random_draw;

    modport source (
        output valid, mode, seq_number, source_number, toward_b, body_length,
               random_draw,
        input  ready
    );
    modport sink (
        input  valid, mode, seq_number, source_number, toward_b, body_length,
               random_draw,
        output ready
    );
endinterface

interface odf_rsp_if import odf_pkg::*; #(
    parameter int LENGTH_BITS = ODF_LENGTH_BITS
);
    logic                   valid;
    logic                   ready;
    logic [OUTCOME_W-1:0]   outcome;
    logic [SEQ_W-1:0]       out_seq_number;
    logic [SRC_W-1:0]       out_source_number;
    logic                   out_toward_b;
    logic [LENGTH_BITS-1:0] out_body_length;
    logic [OCC_W-1:0]       occupancy;
    logic [LEVEL_W-1:0]     drop_level;

    modport source (
        output valid, outcome, out_seq_number, out_source_number, out_toward_b,
               out_body_length, occupancy, drop_level,
        input  ready
    );
    modport sink (
        input  valid, outcome, out_seq_number, out_source_number, out_toward_b,
               out_body_length, occupancy, drop_level,
        output ready
    );
endinterface

[hdl/odf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odf_front: request intake and command queue
// Decodes each request into a control word and a packed descriptor and holds
// them in a two-entry queue until the back end takes them.
// ----------------------------------------------------------------------------
module odf_front import odf_pkg::*; #(
    parameter  int LENGTH_BITS = ODF_LENGTH_BITS,
    localparam int ENTRY_W     = SEQ_W + SRC_W + 1 + LENGTH_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    odf_req_if.sink            req,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output odf_cmd_t           cmd_ctl,
    output logic [ENTRY_W-1:0] cmd_entry
);

    logic [ENTRY_W-1:0]  q_entry_reg [FQ_DEPTH];
    odf_cmd_t            q_ctl_reg   [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FQ_CNT_W-1:0] fill_reg, fill_next;
    logic                push;
    logic                pop;
    odf_cmd_t            in_ctl;
    logic [ENTRY_W-1:0]  in_entry;

    assign req.ready = (fill_reg != FQ_CNT_W'(FQ_DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign push      = req.valid && req.ready;
    assign pop       = cmd_valid && cmd_ready;

    // classify the request; descriptor fields are don't-care on a forward
    always_comb
    begin
        in_ctl.is_fwd = req.mode;
        in_ctl.draw   = req.random_draw;
        in_entry      = {req.seq_number, req.source_number, req.toward_b,
                         req.body_length};
    end

    assign cmd_ctl   = q_ctl_reg[rd_ptr_reg];
    assign cmd_entry = q_entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_ctl_reg[wr_ptr_reg]   <= in_ctl;
            q_entry_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

[hdl/odf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odf_back: drop decision, descriptor store and result stage
// Executes one command per cycle against the occupancy count, writes or
// reads the descriptor memory; a result not yet taken is held and stalls it.
// ----------------------------------------------------------------------------
module odf_back import odf_pkg::*; #(
    parameter  int QUEUE_DEPTH = ODF_QUEUE_DEPTH,
    parameter  int LENGTH_BITS = ODF_LENGTH_BITS,
    localparam int ENTRY_W     = SEQ_W + SRC_W + 1 + LENGTH_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  odf_cmd_t             cmd_ctl,
    input  logic [ENTRY_W-1:0]   cmd_entry,
    odf_rsp_if.source            rsp
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CW    = (CNT_W > REG_W) ? CNT_W : REG_W;

    logic [REG_W-1:0]   low_thr_reg;
    logic [REG_W-1:0]   high_thr_reg;
    logic [REG_W-1:0]   limit_reg;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic               res_valid_reg, res_valid_next;
    outcome_t           res_outcome_reg;
    logic [LEVEL_W-1:0] res_level_reg;
    logic [OCC_W-1:0]   res_occ_reg;
    logic [ENTRY_W-1:0] res_entry_reg;

    logic [CW-1:0]      occ_w, low_w, high_w, lim_w, diff, half, boosted;
    logic [LEVEL_W-1:0] level;
    logic               exec;
    logic               do_push;
    logic               do_pop;
    outcome_t           outcome_next;
    logic [LEVEL_W-1:0] level_next;
    logic [ENTRY_W-1:0] out_entry;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // drop level from the occupancy seen before this command
    always_comb
    begin
        occ_w   = CW'(count_reg);
        low_w   = CW'(low_thr_reg);
        high_w  = CW'(high_thr_reg);
        lim_w   = (CW'(limit_reg) > CW'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH)
                                                      : CW'(limit_reg);
        diff    = occ_w - low_w;
        half    = diff >> 1;
        boosted = (diff > CW'(LEVEL_KNEE)) ? half + CW'(LEVEL_BOOST) : half;
        priority if (occ_w >= high_w)
            level = LEVEL_MAX;
        else if (occ_w < low_w)
            level = LEVEL_NONE;
        else if (boosted > CW'(LEVEL_MAX))
            level = LEVEL_MAX;
        else
            level = LEVEL_W'(boosted);
    end

    assign cmd_ready = !res_valid_reg || rsp.ready;
    assign exec      = cmd_valid && cmd_ready;

    always_comb
    begin
        do_push      = 1'b0;
        do_pop       = 1'b0;
        level_next   = LEVEL_NONE;
        outcome_next = OUT_EMPTY;
        if (cmd_ctl.is_fwd)
        begin
            if (count_reg != '0)
            begin
                do_pop       = exec;
                outcome_next = OUT_FORWARD;
            end
        end
        else
        begin
            level_next = level;
            priority if (cmd_ctl.draw <= level)
                outcome_next = OUT_RANDOM;
            else if (occ_w < lim_w)
            begin
                do_push      = exec;
                outcome_next = OUT_QUEUED;
            end
            else
                outcome_next = OUT_FULL;
        end
    end

    always_comb
    begin
        head_next = do_pop  ? next_ptr(head_reg) : head_reg;
        tail_next = do_push ? next_ptr(tail_reg) : tail_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
        res_valid_next = exec ? 1'b1 : (rsp.ready ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg   <= LOW_THRESHOLD_RESET;
            high_thr_reg  <= HIGH_THRESHOLD_RESET;
            limit_reg     <= QUEUE_LIMIT_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LOW_THRESHOLD:  low_thr_reg  <= cfg_data;
                    CFG_HIGH_THRESHOLD: high_thr_reg <= cfg_data;
                    CFG_QUEUE_LIMIT:    limit_reg    <= cfg_data;
                    default:            ;
                endcase
            end
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // descriptor memory, registered read at the head
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[tail_reg] <= cmd_entry;
        if (do_pop)
            rd_data_reg <= mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            res_outcome_reg <= outcome_next;
            res_level_reg   <= level_next;
            res_occ_reg     <= OCC_W'(count_next);
            res_entry_reg   <= cmd_ctl.is_fwd ? '0 : cmd_entry;
        end
    end

    assign out_entry = (res_outcome_reg == OUT_FORWARD) ? rd_data_reg : res_entry_reg;

    assign rsp.valid             = res_valid_reg;
    assign rsp.outcome           = res_outcome_reg;
    assign rsp.out_seq_number    = out_entry[ENTRY_W-1 -: SEQ_W];
    assign rsp.out_source_number = out_entry[LENGTH_BITS+1 +: SRC_W];
    assign rsp.out_toward_b      = out_entry[LENGTH_BITS];
    assign rsp.out_body_length   = out_entry[LENGTH_BITS-1:0];
    assign rsp.occupancy         = res_occ_reg;
    assign rsp.drop_level        = res_level_reg;

endmodule

[hdl/occupancy_drop_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_drop_fifo: descriptor FIFO with occupancy-based random drop
// Top level joining the request front end and the execution back end.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per transfer: mode 0 is a packet arrival with
//   its descriptor and a random draw, mode 1 asks to forward the head entry.
//   rsp returns exactly one result per request, in request order: outcome,
//   the handled descriptor, occupancy after the step and the drop level.
//   cfg_we/cfg_index/cfg_data write low_threshold (0), high_threshold (1)
//   and queue_limit (2); write them only while no request is in flight.
// Timing:
//   A request taken into the command queue is executed once the back end
//   accepts it, and its result is registered on rsp. One request per cycle is
//   sustained while no held result stalls the back end, which then retires
//   one command per cycle.
// Reset:
//   Count and pointers clear, thresholds return to 11/20/20, both queues
//   empty. The descriptor memory is not cleared; only written entries are read.
// Backpressure:
//   A held result stalls the back end; the two-entry command queue then
//   fills and req.ready drops until rsp.ready returns.
// ----------------------------------------------------------------------------
module occupancy_drop_fifo import odf_pkg::*; #(
    parameter int QUEUE_DEPTH = ODF_QUEUE_DEPTH,
    parameter int LENGTH_BITS = ODF_LENGTH_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    odf_req_if.sink              req,
    odf_rsp_if.source            rsp
);

    localparam int ENTRY_W = SEQ_W + SRC_W + 1 + LENGTH_BITS;

    logic               cmd_valid;
    logic               cmd_ready;
    odf_cmd_t           cmd_ctl;
    logic [ENTRY_W-1:0] cmd_entry;

    odf_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_ctl   (cmd_ctl),
        .cmd_entry (cmd_entry)
    );

    odf_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_ctl   (cmd_ctl),
        .cmd_entry (cmd_entry),
        .rsp       (rsp)
    );

endmodule

[hdl/odf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odf_checker: port-level checks for the occupancy drop FIFO
// Watches the response channel and checks result consistency over time.
// ----------------------------------------------------------------------------
module odf_checker import odf_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic [OUTCOME_W-1:0] outcome,
    input logic [SEQ_W-1:0]     seq_number,
    input logic [OCC_W-1:0]     occupancy,
    input logic [LEVEL_W-1:0]   drop_level
);

    // hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(outcome) && $stable(seq_number))
        else $error("stalled result changed");

    a_empty_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && outcome == OUT_EMPTY |->
            occupancy == '0 && drop_level == LEVEL_NONE)
        else $error("empty report with nonzero occupancy or level");

    a_fwd_level: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && outcome == OUT_FORWARD |-> drop_level == LEVEL_NONE)
        else $error("forward result carries a drop level");

    a_queued_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && outcome == OUT_QUEUED |-> occupancy != '0)
        else $error("queued result with zero occupancy");

endmodule

bind occupancy_drop_fifo odf_checker u_odf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .outcome    (rsp.outcome),
    .seq_number (rsp.out_seq_number),
    .occupancy  (rsp.occupancy),
    .drop_level (rsp.drop_level)
);

[dv/occupancy_drop_fifo_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_drop_fifo_tb: self-checking bench for the occupancy drop FIFO
// Drives arrival and forward requests with bursty gaps and random response
// stalls, and runs through several threshold and limit settings. A
// scoreboard tracks the queue contents and drop decisions, and checks every
// response field by field, in order.
// ----------------------------------------------------------------------------
module occupancy_drop_fifo_tb;
    import odf_pkg::*;

    localparam logic MODE_ARRIVAL = 1'b0;
    localparam logic MODE_FORWARD = 1'b1;
    localparam int   NUM_PHASES   = 8;
    localparam int   PHASE_ITEMS  = 225;

    typedef struct {
        logic                       mode;
        logic [SEQ_W-1:0]           seq;
        logic [SRC_W-1:0]           src;
        logic                       dir;
        logic [ODF_LENGTH_BITS-1:0] len;
        logic [DRAW_W-1:0]          draw;
    } request_t;

    typedef struct {
        outcome_t                   outcome;
        logic [SEQ_W-1:0]           seq;
        logic [SRC_W-1:0]           src;
        logic                       dir;
        logic [ODF_LENGTH_BITS-1:0] len;
        logic [OCC_W-1:0]           occ;
        logic [LEVEL_W-1:0]         level;
    } result_t;

    class drop_queue_checker;
        result_t          pending_results[$];
        request_t         entries[ODF_QUEUE_DEPTH];
        int               head;
        int               tail;
        int               count;
        logic [REG_W-1:0] low_thr;
        logic [REG_W-1:0] high_thr;
        logic [REG_W-1:0] limit_reg;
        int               errors;
        int               checked;
        int               peak_occupancy;
        int               outcome_seen[5];
        string            field_names[7];

        function new();
            head      = 0;
            tail      = 0;
            count     = 0;
            low_thr   = LOW_THRESHOLD_RESET;
            high_thr  = HIGH_THRESHOLD_RESET;
            limit_reg = QUEUE_LIMIT_RESET;
            errors    = 0;
            checked   = 0;
            peak_occupancy = 0;
            foreach (outcome_seen[i]) outcome_seen[i] = 0;
            field_names = '{"outcome", "out_seq_number", "out_source_number",
                            "out_toward_b", "out_body_length", "occupancy",
                            "drop_level"};
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
            case (idx)
                CFG_LOW_THRESHOLD:  low_thr   = value;
                CFG_HIGH_THRESHOLD: high_thr  = value;
                CFG_QUEUE_LIMIT:    limit_reg = value;
                default: ;
            endcase
        endfunction

        // high threshold wins even when it sits below the low threshold
        function logic [LEVEL_W-1:0] level_at(int occ);
            int d;
            int lv;
            if (occ >= high_thr)
                return LEVEL_MAX;
            if (occ < low_thr)
                return LEVEL_NONE;
            d  = occ - low_thr;
            lv = (d > LEVEL_KNEE) ? d / 2 + LEVEL_BOOST : d / 2;
            if (lv > LEVEL_MAX)
                return LEVEL_MAX;
            return LEVEL_W'(lv);
        endfunction

        function void note_request(request_t r);
            result_t  res;
            request_t e;
            int       cap;
            res = '{outcome: OUT_QUEUED, default: '0};
            if (r.mode == MODE_ARRIVAL) begin
                cap = (limit_reg > ODF_QUEUE_DEPTH) ? ODF_QUEUE_DEPTH : int'(limit_reg);
                res.seq   = r.seq;
                res.src   = r.src;
                res.dir   = r.dir;
                res.len   = r.len;
                res.level = level_at(count);
                if (r.draw <= res.level) begin
                    res.outcome = OUT_RANDOM;
                end
                else if (count < cap) begin
                    entries[tail] = r;
                    tail = (tail + 1) % ODF_QUEUE_DEPTH;
                    count++;
                    res.outcome = OUT_QUEUED;
                end
                else begin
                    res.outcome = OUT_FULL;
                end
            end
            else if (count == 0) begin
                res.outcome = OUT_EMPTY;
            end
            else begin
                e = entries[head];
                head = (head + 1) % ODF_QUEUE_DEPTH;
                count--;
                res.outcome = OUT_FORWARD;
                res.seq = e.seq;
                res.src = e.src;
                res.dir = e.dir;
                res.len = e.len;
            end
            res.occ = OCC_W'(count);
            if (count > peak_occupancy)
                peak_occupancy = count;
            pending_results.push_back(res);
        endfunction

        function void check_result(result_t got);
            result_t     want;
            logic [15:0] w[7];
            logic [15:0] g[7];
            if (pending_results.size() == 0) begin
                $display("%0t: response with nothing pending, outcome %0d seq %0d",
                         $time, got.outcome, got.seq);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            w = '{16'(want.outcome), want.seq, 16'(want.src), 16'(want.dir),
                  16'(want.len), 16'(want.occ), 16'(want.level)};
            g = '{16'(got.outcome), got.seq, 16'(got.src), 16'(got.dir),
                  16'(got.len), 16'(got.occ), 16'(got.level)};
            foreach (w[i]) begin
                if (w[i] !== g[i]) begin
                    $display("%0t: %s expected %0d actual %0d",
                             $time, field_names[i], w[i], g[i]);
                    errors++;
                end
            end
            checked++;
            if (want.outcome <= OUT_EMPTY)
                outcome_seen[want.outcome]++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_data;

    odf_req_if req_ch ();
    odf_rsp_if rsp_ch ();

    drop_queue_checker sb;
    int stall_style;
    int stall_left;
    int settings_used;

    occupancy_drop_fifo i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // response stalls: switch between free-running, light, heavy and blocky segments
    always @(negedge clk)
    begin
        if (stall_left <= 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(20, 150);
        end
        stall_left--;
        case (stall_style)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= ((stall_left % 16) < 8);
        endcase
    end

    always @(posedge clk)
    begin : response_monitor
        result_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.outcome = rsp_ch.outcome;
            got.seq     = rsp_ch.out_seq_number;
            got.src     = rsp_ch.out_source_number;
            got.dir     = rsp_ch.out_toward_b;
            got.len     = rsp_ch.out_body_length;
            got.occ     = rsp_ch.occupancy;
            got.level   = rsp_ch.drop_level;
            sb.check_result(got);
        end
    end

    function automatic request_t make_request(logic mode, logic [SEQ_W-1:0] seq,
                                              logic [SRC_W-1:0] src, logic dir,
                                              logic [ODF_LENGTH_BITS-1:0] len,
                                              logic [DRAW_W-1:0] draw);
        request_t r;
        r.mode = mode;
        r.seq  = seq;
        r.src  = src;
        r.dir  = dir;
        r.len  = len;
        r.draw = draw;
        return r;
    endfunction

    function automatic request_t random_request(int arrival_pct);
        request_t r;
        int       pick;
        r.mode = ($urandom_range(0, 99) < arrival_pct) ? MODE_ARRIVAL : MODE_FORWARD;
        r.seq  = SEQ_W'($urandom);
        r.src  = SRC_W'($urandom);
        r.dir  = 1'($urandom);
        r.len  = ODF_LENGTH_BITS'($urandom);
        pick   = $urandom_range(0, 19);
        if (pick == 0)
            r.draw = '0;
        else if (pick == 1)
            r.draw = DRAW_W'($urandom_range(11, 15));
        else
            r.draw = DRAW_W'($urandom_range(1, 10));
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic drive_request(request_t r);
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= r.mode;
        req_ch.seq_number    <= r.seq;
        req_ch.source_number <= r.src;
        req_ch.toward_b      <= r.dir;
        req_ch.body_length   <= r.len;
        req_ch.random_draw   <= r.draw;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(r);
        @(negedge clk);
    endtask

    task automatic idle_cycles(int n);
        req_ch.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // hold off until every response is back, then let the pipeline settle
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_settings(logic [REG_W-1:0] low, logic [REG_W-1:0] high,
                                  logic [REG_W-1:0] limit);
        logic [CFG_IDX_W-1:0] idx[3];
        logic [REG_W-1:0]     val[3];
        idx = '{CFG_LOW_THRESHOLD, CFG_HIGH_THRESHOLD, CFG_QUEUE_LIMIT};
        val = '{low, high, limit};
        cfg_we <= 1'b1;
        for (int i = 0; i < 3; i++) begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            sb.write_register(idx[i], val[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    initial
    begin
        logic [REG_W-1:0] low_set[NUM_PHASES];
        logic [REG_W-1:0] high_set[NUM_PHASES];
        logic [REG_W-1:0] limit_set[NUM_PHASES];
        int sent;
        int burst;
        int pct;
        int wait_cycles;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_LOW_THRESHOLD;
        cfg_data             = '0;
        req_ch.valid         = 1'b0;
        req_ch.mode          = MODE_ARRIVAL;
        req_ch.seq_number    = '0;
        req_ch.source_number = '0;
        req_ch.toward_b      = 1'b0;
        req_ch.body_length   = '0;
        req_ch.random_draw   = '0;
        rsp_ch.ready         = 1'b0;
        stall_style          = 0;
        stall_left           = 0;
        settings_used        = 1;
        sb = new();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: empty forward, field extremes, out-of-range draws
        drive_request(make_request(MODE_FORWARD, '0, '0, 1'b0, '0, '0));
        drive_request(make_request(MODE_ARRIVAL, '1, '1, 1'b1, '1, 4'd1));
        drive_request(make_request(MODE_ARRIVAL, '0, '0, 1'b0, '0, 4'd10));
        drive_request(make_request(MODE_ARRIVAL, 16'h1234, 8'h5a, 1'b1, 11'h2a5, 4'd0));
        drive_request(make_request(MODE_ARRIVAL, 16'hedcb, 8'ha5, 1'b0, 11'h55a, 4'd15));
        repeat (4) drive_request(make_request(MODE_FORWARD, '0, '0, 1'b0, '0, 4'd1));
        settle();

        // fill into the boosted level region until the limit tail-drops
        write_settings(6'd0, 6'd10, 6'd8);
        for (int i = 0; i < 8; i++)
            drive_request(make_request(MODE_ARRIVAL, 16'(i), 8'(i), i[0], 11'(i), 4'd11));
        drive_request(make_request(MODE_ARRIVAL, '1, '0, 1'b1, '0, 4'd9));
        drive_request(make_request(MODE_ARRIVAL, '0, '1, 1'b0, '1, 4'd10));
        drive_request(make_request(MODE_ARRIVAL, 16'h8000, 8'h80, 1'b1, 11'h400, 4'd12));
        settle();

        low_set   = '{6'd11, 6'd0,  6'd63, 6'd5,  6'd0, 6'd2,  6'd0, 6'd0};
        high_set  = '{6'd20, 6'd32, 6'd63, 6'd3,  6'd0, 6'd30, 6'd0, 6'd0};
        limit_set = '{6'd20, 6'd32, 6'd63, 6'd10, 6'd0, 6'd40, 6'd0, 6'd0};
        for (int p = NUM_PHASES - 2; p < NUM_PHASES; p++) begin
            low_set[p]   = REG_W'($urandom_range(0, 24));
            high_set[p]  = REG_W'($urandom_range(8, 40));
            limit_set[p] = REG_W'($urandom_range(1, 36));
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_settings(low_set[p], high_set[p], limit_set[p]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 16);
                case ($urandom_range(0, 2))
                    0:       pct = 85;
                    1:       pct = 50;
                    default: pct = 20;
                endcase
                for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
                    drive_request(random_request(pct));
                    sent++;
                end
                if ($urandom_range(0, 3) != 0)
                    idle_cycles($urandom_range(1, 8));
            end
            settle();
        end

        // drain with a bound so leftovers are reported rather than hanging
        wait_cycles = 0;
        while (sb.pending_results.size() != 0 && wait_cycles < 5000) begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (10) @(negedge clk);
        if (sb.pending_results.size() != 0)
            $display("%0t: %0d responses never arrived", $time, sb.pending_results.size());

        $display("Checked %0d responses across %0d register settings, peak occupancy %0d",
                 sb.checked, settings_used, sb.peak_occupancy);
        $display("Outcomes: queued %0d, random drop %0d, full drop %0d, forwarded %0d, empty %0d",
                 sb.outcome_seen[OUT_QUEUED], sb.outcome_seen[OUT_RANDOM],
                 sb.outcome_seen[OUT_FULL], sb.outcome_seen[OUT_FORWARD],
                 sb.outcome_seen[OUT_EMPTY]);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
